>>> hdl/bps_pkg.sv
// shared types and constants for the byte pattern scanner
package bps_pkg;

  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd1;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_SCAN = 1'b1;

  localparam logic [31:0] OFFSET_MAX = 32'hFFFF_FFFF;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic       shift;
    logic [7:0] enter;
    logic       pat_we;
    logic [7:0] pat_byte;
  } cell_ctl_t;

  // decoded per cell
  typedef struct packed {
    logic insert;
    logic in_use;
    logic pat;
  } cell_sel_t;

endpackage

>>> hdl/bps_in_if.sv
// request channel carrying load and scan bytes
interface bps_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;
  logic [5:0] pattern_index;
  logic       first_of_buffer;

  modport source (output valid, mode, data_byte, pattern_index, first_of_buffer, input ready);
  modport sink   (input valid, mode, data_byte, pattern_index, first_of_buffer, output ready);
endinterface

>>> hdl/bps_out_if.sv
// result channel carrying match addresses
interface bps_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] match_address;

  modport source (output valid, match_address, input ready);
  modport sink   (input valid, match_address, output ready);
endinterface

>>> hdl/bps_cfg_if.sv
// configuration write channel
interface bps_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bps_pkg::CFG_IDX_W-1:0]  index;
  logic [63:0]                    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/bps_cell.sv
// one scanner cell: window byte, aligned window byte, pattern byte and compare
module bps_cell (
  input  logic               clk,
  input  bps_pkg::cell_ctl_t ctl,
  input  bps_pkg::cell_sel_t sel,
  input  logic [7:0]         w_prev,
  input  logic [7:0]         wr_next,
  output logic [7:0]         w_o,
  output logic [7:0]         wr_o,
  output logic               ok_o
);

  logic [7:0] w_r;
  logic [7:0] w_nxt;
  logic [7:0] wr_r;
  logic [7:0] wr_nxt;
  logic [7:0] pat_r;
  logic [7:0] pat_nxt;

  always_comb begin
    w_nxt   = w_r;
    wr_nxt  = wr_r;
    pat_nxt = pat_r;
    if (ctl.shift) begin
      w_nxt  = w_prev;
      wr_nxt = sel.insert ? ctl.enter : wr_next;
    end
    if (ctl.pat_we && sel.pat) begin
      pat_nxt = ctl.pat_byte;
    end
  end

  always_ff @(posedge clk) begin
    w_r   <= w_nxt;
    wr_r  <= wr_nxt;
    pat_r <= pat_nxt;
  end

  assign w_o  = w_r;
  assign wr_o = wr_r;
  assign ok_o = !sel.in_use || (wr_r == pat_r);

endmodule

>>> hdl/byte_pattern_scanner_core.sv
// byte pattern scanner top level: cell chain, offset tracking and result register
// path: a scan request passes the stage-one register, then the result register, before its match address is offered
// throughput: one request per cycle while no realign sweep runs and the result register is not stalled
// after a pattern_length write the chain runs a realign sweep, with requests and writes held off
// reset: synchronous active low; clears offset, fill, length to 1 and base to 0
// pattern bytes are undefined until loaded
module byte_pattern_scanner_core #(
  parameter int PATTERN_MAX = 64
) (
  input logic       clk,
  input logic       rst_n,
  bps_in_if.sink    in_ch,
  bps_out_if.source out_ch,
  bps_cfg_if.sink   cfg_ch
);

  localparam int LW = $clog2(PATTERN_MAX + 1);
  localparam int CW = (LW > 7) ? LW : 7;
  localparam int IW = (LW > 6) ? LW : 6;

  logic [63:0]   base_r,   base_nxt;
  logic [LW-1:0] eff_r,    eff_nxt;
  logic [LW-1:0] fill_r,   fill_nxt;
  logic [31:0]   offset_r, offset_nxt;
  logic [LW-1:0] sweep_r,  sweep_nxt;
  logic          s1_v_r,   s1_v_nxt;
  logic [31:0]   s1_start_r, s1_start_nxt;
  logic          out_v_r,  out_v_nxt;
  logic [63:0]   out_addr_r, out_addr_nxt;

  logic          busy;
  logic          s1_adv;
  logic          in_ready;
  logic          in_acc;
  logic          scan_acc;
  logic          load_acc;
  logic          cfg_acc;
  logic [CW-1:0] len_ext;
  logic [LW-1:0] eff_cfg;
  logic [31:0]   cur;
  logic [LW-1:0] fill_base;
  logic [LW-1:0] fill_step;
  logic          hit;
  logic [IW-1:0] pidx_ext;

  bps_pkg::cell_ctl_t ctl;
  bps_pkg::cell_sel_t sel [PATTERN_MAX];
  logic [7:0]         w_bus [PATTERN_MAX];
  logic [7:0]         wr_bus [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] cell_ok;

  assign busy     = (sweep_r != '0);
  assign s1_adv   = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ready = !busy && (!s1_v_r || s1_adv);
  assign in_acc   = in_ch.valid && in_ready;
  assign scan_acc = in_acc && (in_ch.mode == bps_pkg::MODE_SCAN);
  assign load_acc = in_acc && (in_ch.mode == bps_pkg::MODE_LOAD);
  assign cfg_acc  = cfg_ch.valid && cfg_ch.ready;

  assign in_ch.ready          = in_ready;
  assign cfg_ch.ready         = !busy;
  assign out_ch.valid         = out_v_r;
  assign out_ch.match_address = out_addr_r;

  // length register clamp
  assign len_ext = CW'(cfg_ch.data[6:0]);

  always_comb begin
    if (len_ext == '0) begin
      eff_cfg = LW'(1);
    end else if (len_ext > CW'(PATTERN_MAX)) begin
      eff_cfg = LW'(PATTERN_MAX);
    end else begin
      eff_cfg = LW'(len_ext);
    end
  end

  // offset and fill for the incoming scan byte
  assign cur       = in_ch.first_of_buffer ? 32'd0 : offset_r;
  assign fill_base = in_ch.first_of_buffer ? '0 : fill_r;
  assign fill_step = (fill_base < LW'(PATTERN_MAX)) ? fill_base + LW'(1) : fill_base;

  assign hit = &cell_ok;

  always_comb begin
    base_nxt     = base_r;
    eff_nxt      = eff_r;
    sweep_nxt    = busy ? sweep_r - LW'(1) : sweep_r;
    fill_nxt     = fill_r;
    offset_nxt   = offset_r;
    s1_v_nxt     = s1_v_r;
    s1_start_nxt = s1_start_r;
    out_v_nxt    = out_v_r;
    out_addr_nxt = out_addr_r;

    if (cfg_acc) begin
      case (cfg_ch.index)
        bps_pkg::CFG_BASE_ADDRESS: begin
          base_nxt = cfg_ch.data;
        end
        bps_pkg::CFG_PATTERN_LENGTH: begin
          eff_nxt   = eff_cfg;
          sweep_nxt = LW'(PATTERN_MAX);
        end
        default: begin
        end
      endcase
    end

    if (s1_adv) begin
      out_v_nxt    = hit;
      out_addr_nxt = base_r + 64'(s1_start_r);
      s1_v_nxt     = 1'b0;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end

    if (scan_acc) begin
      fill_nxt     = fill_step;
      offset_nxt   = (cur < bps_pkg::OFFSET_MAX) ? cur + 32'd1 : cur;
      s1_v_nxt     = (fill_step >= eff_r);
      s1_start_nxt = cur - 32'(eff_r) + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      eff_r    <= LW'(1);
      sweep_r  <= '0;
      fill_r   <= '0;
      offset_r <= '0;
      s1_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      base_r   <= base_nxt;
      eff_r    <= eff_nxt;
      sweep_r  <= sweep_nxt;
      fill_r   <= fill_nxt;
      offset_r <= offset_nxt;
      s1_v_r   <= s1_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_start_r <= s1_start_nxt;
    out_addr_r <= out_addr_nxt;
  end

  // realign sweep rotates the window through the insert point
  assign ctl.shift    = scan_acc || busy;
  assign ctl.enter    = busy ? w_bus[PATTERN_MAX-1] : in_ch.data_byte;
  assign ctl.pat_we   = load_acc;
  assign ctl.pat_byte = in_ch.data_byte;

  assign pidx_ext = IW'(in_ch.pattern_index);

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    logic [7:0] w_prev;
    logic [7:0] wr_next;

    if (i == 0) begin : g_first
      assign w_prev = ctl.enter;
    end else begin : g_mid
      assign w_prev = w_bus[i-1];
    end

    if (i == PATTERN_MAX - 1) begin : g_last
      assign wr_next = ctl.enter;
    end else begin : g_inner
      assign wr_next = wr_bus[i+1];
    end

    assign sel[i].insert = (LW'(i) == eff_r - LW'(1));
    assign sel[i].in_use = (LW'(i) < eff_r);
    assign sel[i].pat    = (pidx_ext == IW'(i));

    bps_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .sel     (sel[i]),
      .w_prev  (w_prev),
      .wr_next (wr_next),
      .w_o     (w_bus[i]),
      .wr_o    (wr_bus[i]),
      .ok_o    (cell_ok[i])
    );
  end

`ifndef NO_ASSERTIONS
  a_busy_holds_off: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_ch.ready)
    else $error("request accepted during realign sweep");

  a_hit_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && hit) |=> out_v_r)
    else $error("match lost between compare and output");

  a_len_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_acc && cfg_ch.index == bps_pkg::CFG_PATTERN_LENGTH) |=>
      (sweep_r == LW'(PATTERN_MAX)))
    else $error("length write did not start realign");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= LW'(PATTERN_MAX))
    else $error("fill count above window size");
`endif

endmodule

>>> tb/sv/byte_pattern_scanner_core_tb.sv
// self-checking testbench for the byte pattern scanner core, with a scoreboard of match addresses
module byte_pattern_scanner_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PATTERN_MAX  = 64;
  localparam int DRAIN_CYCLES = 8;
  localparam int ITEM_TARGET  = 1300;
  localparam int PHASE_SCANS  = 110;
  localparam int TIMEOUT_NS   = 5_000_000;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
    logic [5:0] pattern_index;
    logic       first_of_buffer;
  } scan_req_t;

  logic clk = 1'b0;
  logic rst_n;

  bps_in_if  in_if ();
  bps_out_if out_if ();
  bps_cfg_if cfg_if ();

  byte_pattern_scanner_core #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  scan_req_t   req_q[$];
  scan_req_t   cur_req;
  logic [63:0] match_q[$];
  int unsigned req_sent;
  int unsigned req_taken;
  int unsigned scan_pushed;
  int unsigned err_cnt;
  int          in_gap;
  int          out_stall;
  bit          calm;

  logic [7:0]  pat_mem [PATTERN_MAX];
  logic [7:0]  win_mem [PATTERN_MAX];
  logic [6:0]  fill_cnt;
  logic [31:0] byte_ofs;
  logic [63:0] base_reg;
  logic [6:0]  plen_reg;

  logic [7:0]  gen_pat [PATTERN_MAX];

  always #5 clk = ~clk;

  function automatic int eff_len(input logic [6:0] v);
    if (v == 7'd0) return 1;
    if (v > PATTERN_MAX) return PATTERN_MAX;
    return int'(v);
  endfunction

  function automatic int idle_draw();
    if (calm) return 0;
    return $urandom_range(0, 3);
  endfunction

  task automatic scan_predict(input scan_req_t r);
    int          len;
    int          k;
    logic [31:0] cur;
    logic [31:0] start;
    logic        hit;
    if (r.mode == bps_pkg::MODE_LOAD) begin
      pat_mem[r.pattern_index] = r.data_byte;
      return;
    end
    if (r.first_of_buffer) begin
      byte_ofs = '0;
      fill_cnt = '0;
    end
    for (k = PATTERN_MAX - 1; k > 0; k--) win_mem[k] = win_mem[k-1];
    win_mem[0] = r.data_byte;
    if (fill_cnt < PATTERN_MAX) fill_cnt = fill_cnt + 7'd1;
    cur = byte_ofs;
    if (byte_ofs != bps_pkg::OFFSET_MAX) byte_ofs = byte_ofs + 32'd1;
    len = eff_len(plen_reg);
    if (int'(fill_cnt) < len) return;
    hit = 1'b1;
    for (k = 0; k < len; k++) begin
      if (win_mem[k] !== pat_mem[len-1-k]) hit = 1'b0;
    end
    if (!hit) return;
    start = cur - 32'(len - 1);
    match_q.push_back(base_reg + {32'd0, start});
  endtask

  task automatic push_load(input int idx, input logic [7:0] b, input logic first);
    scan_req_t r;
    r.mode            = bps_pkg::MODE_LOAD;
    r.data_byte       = b;
    r.pattern_index   = idx[5:0];
    r.first_of_buffer = first;
    gen_pat[idx[5:0]] = b;
    req_q.push_back(r);
    req_sent++;
  endtask

  task automatic push_scan(input logic [7:0] b, input logic first);
    scan_req_t r;
    r.mode            = bps_pkg::MODE_SCAN;
    r.data_byte       = b;
    r.pattern_index   = 6'($urandom_range(0, 63));
    r.first_of_buffer = first;
    req_q.push_back(r);
    req_sent++;
    scan_pushed++;
  endtask

  task automatic cfg_write(input logic [bps_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    cfg_if.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    if (idx == bps_pkg::CFG_BASE_ADDRESS) base_reg = val;
    else if (idx == bps_pkg::CFG_PATTERN_LENGTH) plen_reg = val[6:0];
  endtask

  task automatic configure(input logic [63:0] base, input logic [6:0] len, input bit len_first);
    if (len_first) begin
      cfg_write(bps_pkg::CFG_PATTERN_LENGTH, {57'd0, len});
      cfg_write(bps_pkg::CFG_BASE_ADDRESS, base);
    end else begin
      cfg_write(bps_pkg::CFG_BASE_ADDRESS, base);
      cfg_write(bps_pkg::CFG_PATTERN_LENGTH, {57'd0, len});
    end
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (req_taken != req_sent || match_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin : req_driver
    scan_req_t nxt;
    logic      fire;
    fire = in_if.valid && in_if.ready;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_gap      <= 0;
    end else begin
      if (fire) begin
        scan_predict(cur_req);
        req_taken++;
      end
      if (!in_if.valid || fire) begin
        if (in_gap != 0) begin
          in_gap      <= in_gap - 1;
          in_if.valid <= 1'b0;
        end else if (req_q.size() != 0) begin
          nxt                    = req_q.pop_front();
          cur_req               <= nxt;
          in_if.mode            <= nxt.mode;
          in_if.data_byte       <= nxt.data_byte;
          in_if.pattern_index   <= nxt.pattern_index;
          in_if.first_of_buffer <= nxt.first_of_buffer;
          in_if.valid           <= 1'b1;
          in_gap                <= idle_draw();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : match_monitor
    logic [63:0] want;
    int          n;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      out_stall    <= 0;
    end else begin
      n = out_stall;
      if (out_if.valid && out_if.ready) begin
        if (match_q.size() == 0) begin
          $error("match_address: expected none, actual %h", out_if.match_address);
          err_cnt++;
        end else begin
          want = match_q.pop_front();
          if (out_if.match_address !== want) begin
            $error("match_address: expected %h, actual %h", want, out_if.match_address);
            err_cnt++;
          end
        end
        n = idle_draw();
      end
      if (n != 0) begin
        out_if.ready <= 1'b0;
        out_stall    <= n - 1;
      end else begin
        out_if.ready <= 1'b1;
        out_stall    <= 0;
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    int          i;
    int          k;
    int          len;
    int          blen;
    int          j;
    int          pick;
    int          cut;
    int          ph;
    int unsigned phase_end;
    logic [6:0]  lsel;
    logic [63:0] base;
    logic [7:0]  sym_a;
    logic [7:0]  sym_b;
    bit          narrow;

    rst_n                 = 1'b0;
    in_if.valid           = 1'b0;
    in_if.mode            = bps_pkg::MODE_LOAD;
    in_if.data_byte       = 8'd0;
    in_if.pattern_index   = 6'd0;
    in_if.first_of_buffer = 1'b0;
    out_if.ready          = 1'b0;
    cfg_if.valid          = 1'b0;
    cfg_if.index          = bps_pkg::CFG_BASE_ADDRESS;
    cfg_if.data           = 64'd0;
    req_sent              = 0;
    req_taken             = 0;
    scan_pushed           = 0;
    err_cnt               = 0;
    calm                  = 1'b0;
    base_reg              = 64'd0;
    plen_reg              = 7'd1;
    fill_cnt              = 7'd0;
    byte_ofs              = 32'd0;
    for (i = 0; i < PATTERN_MAX; i++) begin
      win_mem[i] = 8'd0;
      pat_mem[i] = 8'd0;
      gen_pat[i] = 8'd0;
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // whole pattern store written first, extreme bytes at both ends
    for (i = 0; i < PATTERN_MAX; i++) begin
      push_load(i, (i == 0) ? 8'h00 : (i == PATTERN_MAX - 1) ? 8'hFF : 8'($urandom_range(0, 255)),
                i == 1);
    end
    // single byte pattern at reset settings
    push_scan(8'h00, 1'b1);
    push_scan(8'hFF, 1'b0);
    push_scan(8'h00, 1'b0);
    push_scan(8'h00, 1'b1);
    wait_idle();

    // zero length acts as one, base at all ones wraps around
    configure(64'hFFFF_FFFF_FFFF_FFFF, 7'd0, 1'b0);
    push_scan(8'h00, 1'b1);
    push_scan(8'h00, 1'b0);
    push_scan(8'h7F, 1'b0);
    wait_idle();

    // match on the first two bytes of a buffer, then a buffer shorter than the pattern
    configure(64'h0000_0000_0000_1000, 7'd2, 1'b1);
    push_scan(gen_pat[0], 1'b1);
    push_scan(gen_pat[1], 1'b0);
    push_scan(gen_pat[0], 1'b0);
    push_scan(gen_pat[1], 1'b1);
    wait_idle();

    ph = 0;
    while (req_sent < ITEM_TARGET) begin
      calm = (ph % 4 == 3);
      case (ph)
        0: lsel = 7'd64;
        1: lsel = 7'd127;
        2: lsel = 7'd65;
        3: lsel = 7'd1;
        4: lsel = 7'd0;
        default: begin
          if ($urandom_range(0, 3) != 0) lsel = 7'($urandom_range(2, 8));
          else lsel = 7'($urandom_range(9, 64));
        end
      endcase
      case (ph % 3)
        0: base = {$urandom, $urandom};
        1: base = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 300));
        default: base = 64'd0;
      endcase
      configure(base, lsel, bit'($urandom_range(0, 1)));
      len = eff_len(lsel);

      // narrow alphabet patterns give overlapping matches
      narrow = bit'($urandom_range(0, 1));
      sym_a  = 8'($urandom);
      sym_b  = 8'($urandom);
      for (i = 0; i < len; i++) begin
        push_load(i, narrow ? ($urandom_range(0, 1) ? sym_a : sym_b) : 8'($urandom_range(0, 255)),
                  logic'($urandom_range(0, 1)));
      end

      phase_end = scan_pushed + PHASE_SCANS + 2 * len;
      while (scan_pushed < phase_end) begin
        blen = $urandom_range(1, 2 * len + 12);
        j = 0;
        while (j < blen) begin
          pick = $urandom_range(0, 15);
          if (pick < 4 && blen - j >= len) begin
            for (k = 0; k < len; k++) push_scan(gen_pat[k], j + k == 0);
            j += len;
          end else if (pick == 4) begin
            cut = $urandom_range(1, len);
            for (k = 0; k < cut; k++) push_scan(gen_pat[k], j + k == 0);
            j += cut;
          end else if (pick == 5) begin
            push_load($urandom_range(0, PATTERN_MAX - 1), 8'($urandom_range(0, 255)),
                      logic'($urandom_range(0, 1)));
          end else if (pick == 6) begin
            push_scan(8'($urandom_range(0, 255)), 1'b1);
            j++;
          end else begin
            push_scan((pick < 11) ? gen_pat[$urandom_range(0, len - 1)] :
                      8'($urandom_range(0, 255)), j == 0);
            j++;
          end
        end
      end
      wait_idle();
      ph++;
    end

    wait_idle();
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/bps_pkg.sv
hdl/bps_in_if.sv
hdl/bps_out_if.sv
hdl/bps_cfg_if.sv
hdl/bps_cell.sv
hdl/byte_pattern_scanner_core.sv
tb/sv/byte_pattern_scanner_core_tb.sv
